@@ rtl/core/dve_pkg.sv @@
`timescale 1ns / 1ps

package dve_pkg;

    localparam int NUMBER_WIDTH = 12;
    localparam int STACK_DEPTH  = 32;

    // trial divisors run up to the integer square root, plus one past it
    localparam int SMALL_WIDTH  = (NUMBER_WIDTH + 1) / 2;
    localparam int CAND_WIDTH   = SMALL_WIDTH + 1;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int COUNT_WIDTH  = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CW       = $clog2(NUMBER_WIDTH + 1);

    localparam logic [1:0] EMIT_ZERO  = 2'd0;
    localparam logic [1:0] EMIT_SMALL = 2'd1;
    localparam logic [1:0] EMIT_LARGE = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_sel_small;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        logic       push;
        logic       cand_inc;
        logic       pop;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic sq_le;
        logic div_busy;
        logic rem_zero;
        logic small_sq_eq;
        logic stack_empty;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/dve_datapath.sv @@
`timescale 1ns / 1ps

module dve_datapath
    import dve_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [NUMBER_WIDTH-1:0] o_divisor,
    output logic                    o_found,
    output logic                    o_last
);

    logic [NUMBER_WIDTH-1:0] r_number;
    logic [CAND_WIDTH-1:0]   r_cand;
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [SMALL_WIDTH-1:0]  r_stack [STACK_DEPTH];
    logic [SMALL_WIDTH-1:0]  r_stack_rd;

    logic                    r_div_busy;
    logic [DIV_CW-1:0]       r_div_cnt;
    logic [CAND_WIDTH-1:0]   r_div_d;
    logic [CAND_WIDTH-1:0]   r_div_rem;
    logic [NUMBER_WIDTH-1:0] r_div_quo;

    logic                    r_out_valid;
    logic [NUMBER_WIDTH-1:0] r_out_divisor;
    logic                    r_out_found;
    logic                    r_out_last;

    logic [2*CAND_WIDTH-1:0]  cand_sq;
    logic [2*SMALL_WIDTH-1:0] small_sq;
    logic [CAND_WIDTH:0]      div_trial;
    logic [CAND_WIDTH:0]      div_diff;
    logic                     div_ge;
    logic                     stack_full;
    logic [COUNT_WIDTH-1:0]   pop_idx;

    assign cand_sq    = r_cand * r_cand;
    assign small_sq   = r_stack_rd * r_stack_rd;
    assign div_trial  = {r_div_rem, r_div_quo[NUMBER_WIDTH-1]};
    assign div_diff   = div_trial - {1'b0, r_div_d};
    assign div_ge     = div_trial >= {1'b0, r_div_d};
    assign stack_full = r_count == COUNT_WIDTH'(STACK_DEPTH);
    assign pop_idx    = r_count - 1'b1;

    always_comb begin
        o_status.n_zero      = r_number == '0;
        o_status.n_one       = r_number == NUMBER_WIDTH'(1);
        o_status.sq_le       = cand_sq <= (2*CAND_WIDTH)'(r_number);
        o_status.div_busy    = r_div_busy;
        o_status.rem_zero    = r_div_rem == '0;
        o_status.small_sq_eq = (r_stack_rd == '0)
                            || ((2*CAND_WIDTH)'(small_sq) == (2*CAND_WIDTH)'(r_number));
        o_status.stack_empty = r_count == '0;
        o_status.out_free    = !r_out_valid || !i_stall;
    end

    // operand, candidate and stack bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number <= '0;
            r_cand   <= CAND_WIDTH'(1);
            r_count  <= '0;
        end else if (i_cmd.load) begin
            r_number <= i_number;
            r_cand   <= CAND_WIDTH'(1);
            r_count  <= '0;
        end else begin
            if (i_cmd.cand_inc) begin
                r_cand <= r_cand + 1'b1;
            end
            if (i_cmd.push && !stack_full) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= pop_idx;
            end
        end
    end

    // small divisor stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !stack_full) begin
            r_stack[r_count[STACK_AW-1:0]] <= r_cand[SMALL_WIDTH-1:0];
        end
        if (i_cmd.pop) begin
            r_stack_rd <= r_stack[pop_idx[STACK_AW-1:0]];
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= DIV_CW'(NUMBER_WIDTH);
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == DIV_CW'(1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_d   <= i_cmd.div_sel_small ? {1'b0, r_stack_rd} : r_cand;
            r_div_rem <= '0;
            r_div_quo <= r_number;
        end else if (r_div_busy) begin
            r_div_rem <= div_ge ? div_diff[CAND_WIDTH-1:0] : div_trial[CAND_WIDTH-1:0];
            r_div_quo <= {r_div_quo[NUMBER_WIDTH-2:0], div_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_last <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                EMIT_SMALL: begin
                    r_out_divisor <= NUMBER_WIDTH'(r_cand);
                    r_out_found   <= 1'b1;
                end
                EMIT_LARGE: begin
                    r_out_divisor <= r_div_quo;
                    r_out_found   <= 1'b1;
                end
                default: begin
                    r_out_divisor <= '0;
                    r_out_found   <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_divisor = r_out_divisor;
    assign o_found   = r_out_found;
    assign o_last    = r_out_last;

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("result written over a waiting result");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_div_busy)
        else $error("divider started while busy");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_last && r_out_divisor == '0))
        else $error("empty marker not flagged last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_WIDTH'(STACK_DEPTH))
        else $error("stack count beyond depth");
`endif

endmodule

@@ rtl/core/dve_controller.sv @@
`timescale 1ns / 1ps

module dve_controller
    import dve_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_ZERO  = 4'd2;
    localparam logic [3:0] S_DIVU  = 4'd3;
    localparam logic [3:0] S_EMITU = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_DIVD  = 4'd7;
    localparam logic [3:0] S_EMITD = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.n_zero) begin
                    n_state = S_ZERO;
                end else if (i_status.sq_le) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVU;
                end else begin
                    n_state = S_POP;
                end
            end
            S_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_ZERO;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIVU: begin
                if (!i_status.div_busy) begin
                    if (i_status.rem_zero) begin
                        n_state = S_EMITU;
                    end else begin
                        o_cmd.cand_inc = 1'b1;
                        n_state        = S_CHECK;
                    end
                end
            end
            S_EMITU: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_SMALL;
                    o_cmd.emit_last = i_status.n_one;
                    o_cmd.push      = 1'b1;
                    o_cmd.cand_inc  = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_POP: begin
                if (i_status.stack_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_PRD;
                end
            end
            S_PRD: begin
                // square root of a perfect square has no separate partner
                if (i_status.small_sq_eq) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.div_start     = 1'b1;
                    o_cmd.div_sel_small = 1'b1;
                    n_state             = S_DIVD;
                end
            end
            S_DIVD: begin
                if (!i_status.div_busy) begin
                    n_state = S_EMITD;
                end
            end
            S_EMITD: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_LARGE;
                    o_cmd.emit_last = i_status.stack_empty;
                    n_state         = S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE && i_valid))
        else $error("request loaded outside idle");

    a_no_emit_while_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_status.div_busy)
        else $error("result emitted while divider busy");

    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last && o_cmd.emit_kind != EMIT_SMALL)
            |=> (r_state == S_IDLE || r_state == S_POP))
        else $error("work continued after last result");
`endif

endmodule

@@ rtl/core/divisor_enumerator_unit.sv @@
`timescale 1ns / 1ps

// Lists every divisor of i_number in increasing order, one result per divisor, with
// o_last on the final one; a zero request gives a single result with o_found low. One
// request is worked at a time and i_valid is taken only while o_stall is low. Each
// candidate from 1 up to the square root, and each large partner, goes through the
// shared bit-serial divider. A finished result sits in the output register while the
// next request is already accepted.
module divisor_enumerator_unit
    import dve_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [NUMBER_WIDTH-1:0] o_divisor,
    output logic                    o_found,
    output logic                    o_last
);

    t_cmd    cmd;
    t_status status;

    dve_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dve_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_number  (i_number),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_divisor (o_divisor),
        .o_found   (o_found),
        .o_last    (o_last)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import dve_pkg::*;

    localparam int MAX_RESULTS    = 48;
    localparam int RANDOM_ITEMS   = 78;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] divisor;
        logic                    found;
        logic                    last;
    } t_divisor_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    class divisor_scoreboard;
        t_divisor_result pending_q[$];
        int unsigned     n_requests;
        int unsigned     n_results;
        int unsigned     n_errors;
        int unsigned     most_results;

        // expected divisor list: trial division up to the root, then large partners
        function void note_request(logic [NUMBER_WIDTH-1:0] number);
            int unsigned     value;
            int unsigned     cand;
            int unsigned     depth;
            int unsigned     small_div;
            int unsigned     stack [STACK_DEPTH];
            t_divisor_result list[$];
            value = 32'(number);
            depth = 0;
            n_requests++;
            if (value == 0) begin
                list.push_back('{divisor: '0, found: 1'b0, last: 1'b0});
            end else begin
                for (cand = 1; cand * cand <= value; cand++) begin
                    if (value % cand == 0) begin
                        if (list.size() < MAX_RESULTS)
                            list.push_back('{divisor: cand[NUMBER_WIDTH-1:0], found: 1'b1,
                                             last: 1'b0});
                        if (depth < STACK_DEPTH) begin
                            stack[depth] = cand % (1 << SMALL_WIDTH);
                            depth++;
                        end
                    end
                end
                while (depth > 0) begin
                    depth--;
                    small_div = stack[depth];
                    if (small_div != 0 && small_div * small_div != value
                            && list.size() < MAX_RESULTS) begin
                        cand = value / small_div;
                        list.push_back('{divisor: cand[NUMBER_WIDTH-1:0], found: 1'b1,
                                         last: 1'b0});
                    end
                end
            end
            list[list.size() - 1].last = 1'b1;
            if (list.size() > most_results)
                most_results = list.size();
            foreach (list[i])
                pending_q.push_back(list[i]);
        endfunction

        function void check_result(logic [NUMBER_WIDTH-1:0] divisor, logic found, logic last);
            t_divisor_result want;
            n_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result: divisor %0d found %0d last %0d", divisor, found, last);
                n_errors++;
                return;
            end
            want = pending_q.pop_front();
            if (divisor !== want.divisor) begin
                $error("divisor mismatch: expected %0d, actual %0d", want.divisor, divisor);
                n_errors++;
            end
            if (found !== want.found) begin
                $error("found mismatch: expected %0d, actual %0d", want.found, found);
                n_errors++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, last);
                n_errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [NUMBER_WIDTH-1:0] i_number;
    logic                    o_valid;
    logic                    i_stall;
    logic [NUMBER_WIDTH-1:0] o_divisor;
    logic                    o_found;
    logic                    o_last;

    divisor_scoreboard sb = new;

    int unsigned burst_left;
    int unsigned quiet_cycles;
    int unsigned stall_window;
    t_stall_mode stall_mode;

    int unsigned corner_numbers[] = '{0, 1, 2, 3, 4, 7, 9, 16, 36, 64, 720, 1024, 1365, 2048,
                                      2520, 2730, 3600, 3969, 4032, 4093, 4094, 4095};
    int unsigned rich_numbers[] = '{360, 720, 840, 1260, 1680, 2520, 2880, 3360, 3600, 3780};

    divisor_enumerator_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_number  (i_number),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_divisor (o_divisor),
        .o_found   (o_found),
        .o_last    (o_last)
    );

    always #1 i_clk = ~i_clk;

    // receiver: check accepted results, stall in randomly chosen modes
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_divisor, o_found, o_last);
        if (stall_window == 0) begin
            stall_mode   = t_stall_mode'($urandom_range(0, 3));
            stall_window = $urandom_range(50, 400);
        end else begin
            stall_window--;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
            STALL_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
            default:     i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_number(input logic [NUMBER_WIDTH-1:0] number);
        i_valid  <= 1'b1;
        i_number <= number;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(number);
    endtask

    // bursts of random length, gaps mostly short and now and then long
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 7);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [NUMBER_WIDTH-1:0] pick_number();
        int unsigned root;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return NUMBER_WIDTH'($urandom_range(0, 4095));
            5, 6:          return NUMBER_WIDTH'($urandom_range(0, 63));
            7: begin
                root = $urandom_range(1, 63);
                return NUMBER_WIDTH'(root * root);
            end
            8: return NUMBER_WIDTH'(rich_numbers[$urandom_range(0, rich_numbers.size() - 1)]);
            default:       return NUMBER_WIDTH'($urandom_range(4032, 4095));
        endcase
    endfunction

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_number     = '0;
        i_stall      = 1'b0;
        burst_left   = 0;
        quiet_cycles = 0;
        stall_window = 0;
        stall_mode   = STALL_NONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_numbers[i]) begin
            send_number(NUMBER_WIDTH'(corner_numbers[i]));
            pace_sender();
        end
        repeat (RANDOM_ITEMS) begin
            send_number(pick_number());
            pace_sender();
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, rest random) and %0d results",
                 sb.n_requests, corner_numbers.size(), sb.n_results);
        $display("largest divisor list was %0d results, under random output stalls",
                 sb.most_results);
        if (sb.n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ divisor_enumerator_unit.f @@
rtl/core/dve_pkg.sv
rtl/core/dve_datapath.sv
rtl/core/dve_controller.sv
rtl/core/divisor_enumerator_unit.sv
tb/testbench.sv
